// ===== src/udp_relay_session_table_defines.svh =====
// assertion macros for the udp relay session table checker
`ifndef UDP_RELAY_SESSION_TABLE_DEFINES_SVH
`define UDP_RELAY_SESSION_TABLE_DEFINES_SVH

// same-cycle implication under reset disable
`define URST_ASSERT_IMPL(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("urst assertion failed");

// next-cycle implication under reset disable
`define URST_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("urst assertion failed");

`endif

// ===== src/urst_pkg.sv =====
// shared types and constants of the udp relay session table
package urst_pkg;

    localparam int TABLE_ENTRIES_DEF = 256;
    localparam int QUEUE_DEPTH = 2;

    // command codes
    localparam logic [2:0] CMD_ADD_V4  = 3'd0;
    localparam logic [2:0] CMD_ADD_V6  = 3'd1;
    localparam logic [2:0] CMD_LOOKUP  = 3'd2;
    localparam logic [2:0] CMD_INBOUND = 3'd3;
    localparam logic [2:0] CMD_EXPIRE  = 3'd4;

    // status codes
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_DUP    = 3'd1;
    localparam logic [2:0] ST_FULL   = 3'd2;
    localparam logic [2:0] ST_NOSESS = 3'd3;
    localparam logic [2:0] ST_SHORT  = 3'd4;

    // header lengths and address types
    localparam logic [8:0] HDR_V4 = 9'd10;
    localparam logic [8:0] HDR_V6 = 9'd22;
    localparam logic [8:0] HDR_DOMAIN_BASE = 9'd7;
    localparam logic [7:0] ATYP_V6     = 8'h04;
    localparam logic [7:0] ATYP_DOMAIN = 8'h03;

    // configuration register indexes and resets
    localparam logic [7:0]  CFG_IDLE_TIMEOUT = 8'd0;
    localparam logic [7:0]  CFG_RELAY_PORT   = 8'd1;
    localparam logic [31:0] IDLE_RESET       = 32'd120000;

    typedef enum logic [2:0] {
        OP_ADD,
        OP_LOOKUP,
        OP_INBOUND,
        OP_EXPIRE,
        OP_NONE
    } op_t;

    // classified word passed from front to back
    typedef struct packed {
        op_t         op;
        logic        is_v6;
        logic [31:0] now_ms;
        logic [31:0] cli_addr;
        logic [15:0] cli_port;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [15:0] dst_port;
        logic [31:0] proxy_addr;
        logic [15:0] proxy_port;
        logic [7:0]  slot;
        logic [15:0] datagram_len;
        logic [8:0]  in_hl;
        logic        in_short;
    } item_t;

    typedef struct packed {
        logic  valid;
        item_t item;
    } push_t;

    // result word
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  hit_slot;
        logic [15:0] assigned_port;
        logic [8:0]  hdr_len;
        logic [63:0] out_dest_high;
        logic [63:0] out_dest_low;
        logic [15:0] out_dest_port;
        logic        out_is_ipv6;
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [16:0] forward_len;
        logic [8:0]  expired_count;
    } result_t;

endpackage

// ===== src/udp_relay_session_table.sv =====
// top level of the udp relay session table
// Session table for SOCKS5 UDP relaying, one result word per input word. Add, outbound
// lookup and expire walk the whole table through the single read port of the entry memory,
// one entry per cycle; inbound reads only the entry that its slot names, and unused commands
// read none. A two-word queue sits between the input and the table sequencer, so new
// words are taken while a result waits. Entry valid bits are flip-flops cleared by reset,
// so no clearing pass is needed. Config writes are always ready and must only be issued
// while the block is idle.
module udp_relay_session_table #(
    parameter int TABLE_ENTRIES = urst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [31:0] now_ms,
    input  logic [31:0] cli_addr,
    input  logic [15:0] cli_port,
    input  logic [63:0] dest_high,
    input  logic [63:0] dest_low,
    input  logic [15:0] dst_port,
    input  logic [31:0] proxy_addr,
    input  logic [15:0] proxy_port,
    input  logic [7:0]  slot,
    input  logic [15:0] datagram_len,
    input  logic [15:0] header_bytes,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [7:0]  hit_slot,
    output logic [15:0] assigned_port,
    output logic [8:0]  hdr_len,
    output logic [63:0] out_dest_high,
    output logic [63:0] out_dest_low,
    output logic [15:0] out_dest_port,
    output logic        out_is_ipv6,
    output logic [31:0] peer_ip,
    output logic [15:0] peer_port,
    output logic [16:0] forward_len,
    output logic [8:0]  expired_count
);
    import urst_pkg::*;

    push_t   push;
    item_t   head;
    logic    q_empty;
    logic    q_full;
    logic    pop;
    result_t res;

    assign cfg_ready = 1'b1;

    // front end
    urst_front u_front (
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .now_ms       (now_ms),
        .cli_addr     (cli_addr),
        .cli_port     (cli_port),
        .dest_high    (dest_high),
        .dest_low     (dest_low),
        .dst_port     (dst_port),
        .proxy_addr   (proxy_addr),
        .proxy_port   (proxy_port),
        .slot         (slot),
        .datagram_len (datagram_len),
        .header_bytes (header_bytes),
        .q_full       (q_full),
        .push         (push)
    );

    // queue
    urst_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .empty (q_empty),
        .full  (q_full)
    );

    // back end
    urst_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res       (res)
    );

    // result fields
    assign status        = res.status;
    assign hit_slot      = res.hit_slot;
    assign assigned_port = res.assigned_port;
    assign hdr_len       = res.hdr_len;
    assign out_dest_high = res.out_dest_high;
    assign out_dest_low  = res.out_dest_low;
    assign out_dest_port = res.out_dest_port;
    assign out_is_ipv6   = res.out_is_ipv6;
    assign peer_ip       = res.peer_ip;
    assign peer_port     = res.peer_port;
    assign forward_len   = res.forward_len;
    assign expired_count = res.expired_count;

endmodule

// ===== src/urst_front.sv =====
// front end: accepts input words and classifies commands
module urst_front (
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [2:0]     command,
    input  logic [31:0]    now_ms,
    input  logic [31:0]    cli_addr,
    input  logic [15:0]    cli_port,
    input  logic [63:0]    dest_high,
    input  logic [63:0]    dest_low,
    input  logic [15:0]    dst_port,
    input  logic [31:0]    proxy_addr,
    input  logic [15:0]    proxy_port,
    input  logic [7:0]     slot,
    input  logic [15:0]    datagram_len,
    input  logic [15:0]    header_bytes,
    input  logic           q_full,
    output urst_pkg::push_t push
);
    import urst_pkg::*;

    logic [7:0] atyp;
    logic [8:0] parsed_hl;
    logic       short_len;
    logic       short_hl;
    logic       is_v6;

    assign in_stall = q_full;
    assign atyp     = header_bytes[15:8];
    assign is_v6    = (command == CMD_ADD_V6);

    // inbound header length by address type
    always_comb
    begin
        if (atyp == ATYP_V6)
            parsed_hl = HDR_V6;
        else if (atyp == ATYP_DOMAIN)
            parsed_hl = HDR_DOMAIN_BASE + {1'b0, header_bytes[7:0]};
        else
            parsed_hl = HDR_V4;
    end

    assign short_len = (datagram_len <= {7'b0, HDR_V4});
    assign short_hl  = (datagram_len <= {7'b0, parsed_hl});

    // command decode and payload shaping
    always_comb
    begin
        push.valid = in_valid && !q_full;
        unique case (command)
            CMD_ADD_V4, CMD_ADD_V6: push.item.op = OP_ADD;
            CMD_LOOKUP:             push.item.op = OP_LOOKUP;
            CMD_INBOUND:            push.item.op = OP_INBOUND;
            CMD_EXPIRE:             push.item.op = OP_EXPIRE;
            default:                push.item.op = OP_NONE;
        endcase
        push.item.is_v6        = is_v6;
        push.item.now_ms       = now_ms;
        push.item.cli_addr     = cli_addr;
        push.item.cli_port     = cli_port;
        push.item.dest_high    = is_v6 ? dest_high : 64'b0;
        push.item.dest_low     = is_v6 ? dest_low : {32'b0, dest_low[31:0]};
        push.item.dst_port     = dst_port;
        push.item.proxy_addr   = proxy_addr;
        push.item.proxy_port   = proxy_port;
        push.item.slot         = slot;
        push.item.datagram_len = datagram_len;
        push.item.in_hl        = short_len ? 9'b0 : parsed_hl;
        push.item.in_short     = short_len || short_hl;
    end

endmodule

// ===== src/urst_queue.sv =====
// short queue between front and back
module urst_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  urst_pkg::push_t push,
    input  logic            pop,
    output urst_pkg::item_t head,
    output logic            empty,
    output logic            full
);
    import urst_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t            slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head  = slots_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push.valid)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push.valid && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push.valid)
                count_reg <= count_reg - 1'b1;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (push.valid)
            slots_reg[wr_ptr_reg] <= push.item;
    end

endmodule

// ===== src/urst_back.sv =====
// back end: session memory, table scan sequencer and result register
module urst_back #(
    parameter int TABLE_ENTRIES = urst_pkg::TABLE_ENTRIES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  urst_pkg::item_t   head,
    input  logic              q_empty,
    output logic              pop,
    input  logic              cfg_we,
    input  logic [7:0]        cfg_index,
    input  logic [31:0]       cfg_data,
    output logic              out_valid,
    input  logic              out_stall,
    output urst_pkg::result_t res
);
    import urst_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef struct packed {
        logic [31:0] cli_addr;
        logic [15:0] cli_port;
        logic [63:0] dest_high;
        logic [63:0] dest_low;
        logic [15:0] dst_port;
        logic        is_v6;
        logic [31:0] proxy_addr;
        logic [15:0] proxy_port;
        logic [31:0] last_seen;
    } rec_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_FIN
    } state_t;

    rec_t             mem [TABLE_ENTRIES];
    rec_t             rd_data_reg;
    logic             valid_reg [TABLE_ENTRIES];

    state_t           state_reg;
    item_t            cur_reg;
    logic [CNT_W-1:0] scan_cnt_reg;
    logic             pend_reg;
    logic [IDX_W-1:0] cmp_idx_reg;
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    rec_t             hit_rec_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;
    logic [8:0]       exp_cnt_reg;
    logic [31:0]      idle_timeout_reg;
    logic [15:0]      relay_port_reg;
    logic             out_valid_reg;
    result_t          res_reg;

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    rec_t             wr_data;
    logic             set_valid;
    result_t          res_next;
    logic             load;
    logic             key_eq;
    logic             aged;
    logic [IDX_W-1:0] cur_slot_idx;
    logic             cur_in_range;
    logic [8:0]       lookup_hl;

    function automatic logic [IDX_W-1:0] to_idx(input logic [7:0] s);
        logic [IDX_W+7:0] ext;
        ext = {{IDX_W{1'b0}}, s};
        return ext[IDX_W-1:0];
    endfunction

    function automatic logic [7:0] to_slot8(input logic [IDX_W-1:0] idx);
        logic [IDX_W+7:0] ext;
        ext = {8'b0, idx};
        return ext[7:0];
    endfunction

    assign out_valid    = out_valid_reg;
    assign res          = res_reg;
    assign pop          = (state_reg == S_IDLE) && !q_empty;
    assign load         = (state_reg == S_FIN) && (!out_valid_reg || !out_stall);
    assign cur_slot_idx = to_idx(cur_reg.slot);
    assign cur_in_range = ({24'b0, cur_reg.slot} < 32'(TABLE_ENTRIES));
    assign key_eq       = (rd_data_reg.cli_addr == cur_reg.cli_addr)
                          && (rd_data_reg.cli_port == cur_reg.cli_port);
    assign aged         = ((cur_reg.now_ms - rd_data_reg.last_seen) > idle_timeout_reg);
    assign lookup_hl    = hit_rec_reg.is_v6 ? HDR_V6 : HDR_V4;

    // memory read port selection
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = scan_cnt_reg[IDX_W-1:0];
        if (state_reg == S_SCAN)
            rd_en = 1'b1;
        else if (pop && (head.op == OP_INBOUND))
        begin
            rd_en   = 1'b1;
            rd_addr = to_idx(head.slot);
        end
    end

    // result and write-back of the finishing word
    always_comb
    begin
        res_next  = '0;
        wr_en     = 1'b0;
        wr_addr   = free_idx_reg;
        wr_data   = rd_data_reg;
        set_valid = 1'b0;
        case (cur_reg.op)
            OP_ADD:
            begin
                if (hit_found_reg)
                begin
                    res_next.status        = ST_DUP;
                    res_next.hit_slot      = to_slot8(hit_idx_reg);
                    res_next.assigned_port = relay_port_reg;
                end
                else if (free_found_reg)
                begin
                    res_next.status        = ST_OK;
                    res_next.hit_slot      = to_slot8(free_idx_reg);
                    res_next.assigned_port = relay_port_reg;
                    wr_en                  = 1'b1;
                    set_valid              = 1'b1;
                    wr_data.cli_addr       = cur_reg.cli_addr;
                    wr_data.cli_port       = cur_reg.cli_port;
                    wr_data.dest_high      = cur_reg.dest_high;
                    wr_data.dest_low       = cur_reg.dest_low;
                    wr_data.dst_port       = cur_reg.dst_port;
                    wr_data.is_v6          = cur_reg.is_v6;
                    wr_data.proxy_addr     = cur_reg.proxy_addr;
                    wr_data.proxy_port     = cur_reg.proxy_port;
                    wr_data.last_seen      = cur_reg.now_ms;
                end
                else
                    res_next.status = ST_FULL;
            end
            OP_LOOKUP:
            begin
                if (!hit_found_reg)
                    res_next.status = ST_NOSESS;
                else
                begin
                    res_next.hit_slot = to_slot8(hit_idx_reg);
                    if (cur_reg.datagram_len == 16'b0)
                        res_next.status = ST_SHORT;
                    else
                    begin
                        res_next.status        = ST_OK;
                        res_next.hdr_len       = lookup_hl;
                        res_next.out_dest_high = hit_rec_reg.dest_high;
                        res_next.out_dest_low  = hit_rec_reg.dest_low;
                        res_next.out_dest_port = hit_rec_reg.dst_port;
                        res_next.out_is_ipv6   = hit_rec_reg.is_v6;
                        res_next.peer_ip       = hit_rec_reg.proxy_addr;
                        res_next.peer_port     = hit_rec_reg.proxy_port;
                        res_next.forward_len   = {1'b0, cur_reg.datagram_len}
                                                 + {8'b0, lookup_hl};
                        wr_en                  = 1'b1;
                        wr_addr                = hit_idx_reg;
                        wr_data                = hit_rec_reg;
                        wr_data.last_seen      = cur_reg.now_ms;
                    end
                end
            end
            OP_INBOUND:
            begin
                if (!cur_in_range || !valid_reg[cur_slot_idx])
                    res_next.status = ST_NOSESS;
                else
                begin
                    res_next.hit_slot = cur_reg.slot;
                    res_next.hdr_len  = cur_reg.in_hl;
                    if (cur_reg.in_short)
                        res_next.status = ST_SHORT;
                    else
                    begin
                        res_next.status      = ST_OK;
                        res_next.peer_ip     = rd_data_reg.cli_addr;
                        res_next.peer_port   = rd_data_reg.cli_port;
                        res_next.forward_len = {1'b0, cur_reg.datagram_len}
                                               - {8'b0, cur_reg.in_hl};
                        wr_en                = 1'b1;
                        wr_addr              = cur_slot_idx;
                        wr_data.last_seen    = cur_reg.now_ms;
                    end
                end
            end
            OP_EXPIRE:
            begin
                res_next.status        = ST_OK;
                res_next.expired_count = exp_cnt_reg;
            end
            default:
                res_next = '0;
        endcase
    end

    // session memory
    always_ff @(posedge clk)
    begin
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
        if (load && wr_en)
            mem[wr_addr] <= wr_data;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg <= IDLE_RESET;
            relay_port_reg   <= 16'b0;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_IDLE_TIMEOUT)
                idle_timeout_reg <= cfg_data;
            else if (cfg_index == CFG_RELAY_PORT)
                relay_port_reg <= cfg_data[15:0];
        end
    end

    // entry valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_ENTRIES; i++)
                valid_reg[i] <= 1'b0;
        end
        else
        begin
            if (pend_reg && (cur_reg.op == OP_EXPIRE) && valid_reg[cmp_idx_reg] && aged)
                valid_reg[cmp_idx_reg] <= 1'b0;
            if (load && set_valid)
                valid_reg[free_idx_reg] <= 1'b1;
        end
    end

    // sequencer, scan compare stage and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            scan_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            cmp_idx_reg    <= '0;
            hit_found_reg  <= 1'b0;
            hit_idx_reg    <= '0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            exp_cnt_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            // compare the entry read in the previous cycle
            if (pend_reg)
            begin
                if ((cur_reg.op == OP_ADD) || (cur_reg.op == OP_LOOKUP))
                begin
                    if (valid_reg[cmp_idx_reg] && key_eq && !hit_found_reg)
                    begin
                        hit_found_reg <= 1'b1;
                        hit_idx_reg   <= cmp_idx_reg;
                        hit_rec_reg   <= rd_data_reg;
                    end
                    if (!valid_reg[cmp_idx_reg] && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                        free_idx_reg   <= cmp_idx_reg;
                    end
                end
                else if ((cur_reg.op == OP_EXPIRE) && valid_reg[cmp_idx_reg] && aged
                         && (exp_cnt_reg != 9'h1FF))
                    exp_cnt_reg <= exp_cnt_reg + 1'b1;
            end

            // result word taken and no new one loaded
            if (out_valid_reg && !out_stall && !load)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    pend_reg <= 1'b0;
                    if (pop)
                    begin
                        cur_reg        <= head;
                        scan_cnt_reg   <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        exp_cnt_reg    <= '0;
                        if ((head.op == OP_INBOUND) || (head.op == OP_NONE))
                            state_reg <= S_FIN;
                        else
                            state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    pend_reg     <= 1'b1;
                    cmp_idx_reg  <= scan_cnt_reg[IDX_W-1:0];
                    scan_cnt_reg <= scan_cnt_reg + 1'b1;
                    if (scan_cnt_reg == CNT_W'(TABLE_ENTRIES - 1))
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    pend_reg  <= 1'b0;
                    state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    if (load)
                    begin
                        res_reg       <= res_next;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== src/urst_checker.sv =====
// port-level checker for the udp relay session table, with its bind
`include "udp_relay_session_table_defines.svh"

module urst_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [2:0]  status,
    input logic [7:0]  hit_slot,
    input logic [15:0] assigned_port,
    input logic [16:0] forward_len,
    input logic [8:0]  expired_count
);
    import urst_pkg::*;

    // stalled result word stays
    `URST_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `URST_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(status) && $stable(hit_slot))

    // full table reports no slot and no port
    `URST_ASSERT_IMPL(a_full_zero, clk, rst_n, out_valid && (status == ST_FULL), (hit_slot == 8'd0) && (assigned_port == 16'd0))

    // missing session forwards nothing
    `URST_ASSERT_IMPL(a_nosess_zero, clk, rst_n, out_valid && (status == ST_NOSESS), (forward_len == 17'd0) && (expired_count == 9'd0))

endmodule

bind udp_relay_session_table urst_checker u_urst_checker (.*);

// ===== verif/tb_udp_relay_session_table.sv =====
// testbench for the udp relay session table: directed, full-table and random traffic
`timescale 1ns / 1ps

module tb_udp_relay_session_table;
    import urst_pkg::*;

    localparam int NUM_SLOTS = 256;
    localparam int QUIET_LIMIT = 40000;

    typedef struct {
        logic [2:0]  cmd;
        logic [31:0] now;
        logic [31:0] cip;
        logic [15:0] cport;
        logic [63:0] dhi;
        logic [63:0] dlo;
        logic [15:0] dport;
        logic [31:0] rip;
        logic [15:0] rport;
        logic [7:0]  slot;
        logic [15:0] dlen;
        logic [15:0] hdr;
    } request_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  command;
    logic [31:0] now_ms;
    logic [31:0] cli_addr;
    logic [15:0] cli_port;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [15:0] dst_port;
    logic [31:0] proxy_addr;
    logic [15:0] proxy_port;
    logic [7:0]  slot;
    logic [15:0] datagram_len;
    logic [15:0] header_bytes;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        out_valid;
    logic        out_stall;
    logic [2:0]  status;
    logic [7:0]  hit_slot;
    logic [15:0] assigned_port;
    logic [8:0]  hdr_len;
    logic [63:0] out_dest_high;
    logic [63:0] out_dest_low;
    logic [15:0] out_dest_port;
    logic        out_is_ipv6;
    logic [31:0] peer_ip;
    logic [15:0] peer_port;
    logic [16:0] forward_len;
    logic [8:0]  expired_count;

    // shadow session table
    bit          sess_valid [NUM_SLOTS];
    logic [31:0] sess_cip   [NUM_SLOTS];
    logic [15:0] sess_cport [NUM_SLOTS];
    logic [63:0] sess_dhi   [NUM_SLOTS];
    logic [63:0] sess_dlo   [NUM_SLOTS];
    logic [15:0] sess_dport [NUM_SLOTS];
    bit          sess_v6    [NUM_SLOTS];
    logic [31:0] sess_rip   [NUM_SLOTS];
    logic [15:0] sess_rport [NUM_SLOTS];
    logic [31:0] sess_seen  [NUM_SLOTS];
    logic [31:0] idle_timeout;
    logic [15:0] port_cfg;

    result_t     pending_results[$];
    int          errors;
    int          words_sent;
    int          words_checked;
    int          quiet_cycles;
    int          idle_pct;
    int          stall_pct;
    logic [31:0] clock_ms;
    logic [31:0] key_ip [8];
    logic [15:0] key_port [4];

    udp_relay_session_table u_top (.*);

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // session table prediction for one accepted word
    function automatic result_t session_result(request_t w);
        result_t r;
        int      k;
        int      hl;
        r = '0;
        k = -1;
        if (w.cmd == CMD_ADD_V4 || w.cmd == CMD_ADD_V6 || w.cmd == CMD_LOOKUP)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                if (k < 0 && sess_valid[i] && sess_cip[i] == w.cip && sess_cport[i] == w.cport)
                    k = i;
        end
        if (w.cmd == CMD_ADD_V4 || w.cmd == CMD_ADD_V6)
        begin
            if (k >= 0)
            begin
                r.status = ST_DUP;
                r.hit_slot = k[7:0];
                r.assigned_port = port_cfg;
                return r;
            end
            for (int i = 0; i < NUM_SLOTS; i++)
                if (k < 0 && !sess_valid[i])
                    k = i;
            if (k < 0)
            begin
                r.status = ST_FULL;
                return r;
            end
            sess_valid[k] = 1'b1;
            sess_cip[k] = w.cip;
            sess_cport[k] = w.cport;
            sess_v6[k] = (w.cmd == CMD_ADD_V6);
            sess_dhi[k] = (w.cmd == CMD_ADD_V6) ? w.dhi : 64'd0;
            sess_dlo[k] = (w.cmd == CMD_ADD_V6) ? w.dlo : {32'd0, w.dlo[31:0]};
            sess_dport[k] = w.dport;
            sess_rip[k] = w.rip;
            sess_rport[k] = w.rport;
            sess_seen[k] = w.now;
            r.status = ST_OK;
            r.hit_slot = k[7:0];
            r.assigned_port = port_cfg;
        end
        else if (w.cmd == CMD_LOOKUP)
        begin
            if (k < 0)
            begin
                r.status = ST_NOSESS;
                return r;
            end
            r.hit_slot = k[7:0];
            if (w.dlen == 0)
            begin
                r.status = ST_SHORT;
                return r;
            end
            hl = sess_v6[k] ? HDR_V6 : HDR_V4;
            r.status = ST_OK;
            r.hdr_len = hl[8:0];
            r.out_dest_high = sess_dhi[k];
            r.out_dest_low = sess_dlo[k];
            r.out_dest_port = sess_dport[k];
            r.out_is_ipv6 = sess_v6[k];
            r.peer_ip = sess_rip[k];
            r.peer_port = sess_rport[k];
            r.forward_len = 17'(w.dlen + hl);
            sess_seen[k] = w.now;
        end
        else if (w.cmd == CMD_INBOUND)
        begin
            if (!sess_valid[w.slot])
            begin
                r.status = ST_NOSESS;
                return r;
            end
            r.hit_slot = w.slot;
            if (w.dlen <= HDR_V4)
            begin
                r.status = ST_SHORT;
                return r;
            end
            if (w.hdr[15:8] == ATYP_V6)
                hl = HDR_V6;
            else if (w.hdr[15:8] == ATYP_DOMAIN)
                hl = HDR_DOMAIN_BASE + w.hdr[7:0];
            else
                hl = HDR_V4;
            r.hdr_len = hl[8:0];
            if (w.dlen <= hl)
            begin
                r.status = ST_SHORT;
                return r;
            end
            r.status = ST_OK;
            r.peer_ip = sess_cip[w.slot];
            r.peer_port = sess_cport[w.slot];
            r.forward_len = 17'(w.dlen - hl);
            sess_seen[w.slot] = w.now;
        end
        else if (w.cmd == CMD_EXPIRE)
        begin
            for (int i = 0; i < NUM_SLOTS; i++)
                if (sess_valid[i] && 32'(w.now - sess_seen[i]) > idle_timeout)
                begin
                    sess_valid[i] = 1'b0;
                    r.expired_count = r.expired_count + 9'd1;
                end
            r.status = ST_OK;
        end
        return r;
    endfunction

    // send one request word, honoring the sender idle rate
    task automatic send_word(request_t w);
        in_valid = 1'b0;
        while ($urandom_range(99) < idle_pct)
            @(negedge clk);
        command = w.cmd;
        now_ms = w.now;
        cli_addr = w.cip;
        cli_port = w.cport;
        dest_high = w.dhi;
        dest_low = w.dlo;
        dst_port = w.dport;
        proxy_addr = w.rip;
        proxy_port = w.rport;
        slot = w.slot;
        datagram_len = w.dlen;
        header_bytes = w.hdr;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        pending_results.push_back(session_result(w));
        words_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // wait until every expected result is back, then let the block settle
    task automatic drain();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
    endtask

    task automatic cfg_write(logic [7:0] idx, logic [31:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx == CFG_IDLE_TIMEOUT)
            idle_timeout = data;
        else if (idx == CFG_RELAY_PORT)
            port_cfg = data[15:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic request_t blank_word(logic [2:0] cmd);
        request_t w;
        w.cmd = cmd;
        w.now = clock_ms;
        w.cip = '0;
        w.cport = '0;
        w.dhi = '0;
        w.dlo = '0;
        w.dport = '0;
        w.rip = '0;
        w.rport = '0;
        w.slot = '0;
        w.dlen = '0;
        w.hdr = '0;
        return w;
    endfunction

    function automatic request_t add_word(logic [2:0] cmd, logic [31:0] ip, logic [15:0] port);
        request_t w;
        w = blank_word(cmd);
        w.cip = ip;
        w.cport = port;
        w.dhi = {$urandom, $urandom};
        w.dlo = {$urandom, $urandom};
        w.dport = $urandom;
        w.rip = $urandom;
        w.rport = $urandom;
        return w;
    endfunction

    function automatic request_t inbound_word(logic [7:0] s, logic [15:0] len, logic [15:0] hdr);
        request_t w;
        w = blank_word(CMD_INBOUND);
        w.slot = s;
        w.dlen = len;
        w.hdr = hdr;
        return w;
    endfunction

    function automatic request_t lookup_word(logic [31:0] ip, logic [15:0] port,
                                             logic [15:0] len);
        request_t w;
        w = blank_word(CMD_LOOKUP);
        w.cip = ip;
        w.cport = port;
        w.dlen = len;
        return w;
    endfunction

    // edge values, every command and the special cases
    task automatic test_directed();
        request_t w;
        cfg_write(CFG_RELAY_PORT, 32'h0000_ffff);
        w = add_word(CMD_ADD_V4, 32'hffff_ffff, 16'hffff);
        w.dhi = '1;
        w.dlo = '1;
        send_word(w);
        w = add_word(CMD_ADD_V6, 32'h0, 16'h0);
        w.dhi = '1;
        w.dlo = '1;
        w.dport = '1;
        w.rip = '1;
        w.rport = '1;
        send_word(w);
        send_word(add_word(CMD_ADD_V6, 32'hffff_ffff, 16'hffff));
        send_word(lookup_word(32'hffff_ffff, 16'hffff, 16'hffff));
        send_word(lookup_word(32'h0, 16'h0, 16'd1));
        send_word(lookup_word(32'h0, 16'h0, 16'd0));
        send_word(lookup_word(32'h1234_5678, 16'h0, 16'd100));
        // inbound header parsing and short datagrams
        send_word(inbound_word(8'd0, 16'd11, {8'h01, 8'h00}));
        send_word(inbound_word(8'd0, 16'd10, {8'h01, 8'h00}));
        send_word(inbound_word(8'd1, 16'd23, {ATYP_V6, 8'hff}));
        send_word(inbound_word(8'd1, 16'd22, {ATYP_V6, 8'h00}));
        send_word(inbound_word(8'd1, 16'd262, {ATYP_DOMAIN, 8'hff}));
        send_word(inbound_word(8'd1, 16'd263, {ATYP_DOMAIN, 8'hff}));
        send_word(inbound_word(8'd0, 16'hffff, {ATYP_DOMAIN, 8'h00}));
        send_word(inbound_word(8'd0, 16'hffff, 16'hffff));
        send_word(inbound_word(8'hff, 16'd100, 16'h0100));
        // unused commands leave the table alone
        send_word(blank_word(3'd5));
        send_word(blank_word(3'd6));
        w = blank_word(3'd7);
        w.cip = '1;
        w.dlen = '1;
        send_word(w);
        // nothing idle yet, then wrap the clock far ahead
        send_word(blank_word(CMD_EXPIRE));
        drain();
        cfg_write(CFG_IDLE_TIMEOUT, 32'hffff_ffff);
        clock_ms = clock_ms + 32'h8000_0000;
        send_word(blank_word(CMD_EXPIRE));
        drain();
        cfg_write(CFG_IDLE_TIMEOUT, 32'd0);
        clock_ms = clock_ms + 32'd1;
        send_word(blank_word(CMD_EXPIRE));
        drain();
    endtask

    // fill every slot, overflow it twice, then clear them all
    task automatic test_full_table();
        cfg_write(CFG_IDLE_TIMEOUT, IDLE_RESET);
        cfg_write(CFG_RELAY_PORT, 32'd0);
        for (int i = 0; i <= NUM_SLOTS; i++)
            send_word(add_word(i[0] ? CMD_ADD_V6 : CMD_ADD_V4, $urandom, i[15:0]));
        send_word(add_word(CMD_ADD_V4, $urandom, 16'd3));
        send_word(inbound_word(8'hff, 16'd40, 16'h0300));
        clock_ms = clock_ms + IDLE_RESET + 32'd1;
        send_word(blank_word(CMD_EXPIRE));
        drain();
    endtask

    function automatic request_t random_word();
        request_t w;
        int       pick;
        pick = $urandom_range(99);
        clock_ms = clock_ms + (($urandom_range(19) == 0) ? $urandom : $urandom_range(3000));
        if (pick < 32)
        begin
            w = add_word($urandom_range(1) ? CMD_ADD_V6 : CMD_ADD_V4,
                         key_ip[$urandom_range(7)], key_port[$urandom_range(3)]);
            if ($urandom_range(9) == 0)
            begin
                w.cip = $urandom;
                w.cport = $urandom;
            end
        end
        else if (pick < 62)
        begin
            w = lookup_word(key_ip[$urandom_range(7)], key_port[$urandom_range(3)],
                            $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(40)));
            if ($urandom_range(9) == 0)
                w.cip = $urandom;
        end
        else if (pick < 88)
        begin
            w = inbound_word($urandom_range(7) == 0 ? 8'($urandom) : 8'($urandom_range(40)),
                             $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(300)),
                             $urandom);
            case ($urandom_range(3))
                0: w.hdr[15:8] = 8'h01;
                1: w.hdr[15:8] = ATYP_DOMAIN;
                2: w.hdr[15:8] = ATYP_V6;
                default: ;
            endcase
        end
        else if (pick < 95)
            w = blank_word(CMD_EXPIRE);
        else
        begin
            w = add_word(3'($urandom_range(7, 5)), $urandom, $urandom);
            w.slot = $urandom;
            w.dlen = $urandom;
            w.hdr = $urandom;
        end
        w.now = clock_ms;
        return w;
    endfunction

    // random traffic phase under one idle and stall setting
    task automatic test_random_phase(int count, int src_idle, int dst_stall,
                                     logic [31:0] timeout, logic [15:0] port);
        cfg_write(CFG_IDLE_TIMEOUT, timeout);
        cfg_write(CFG_RELAY_PORT, {16'd0, port});
        idle_pct = src_idle;
        stall_pct = dst_stall;
        for (int i = 0; i < count; i++)
        begin
            send_word(random_word());
            // hold off once until every result is back
            if (i == count / 2 && src_idle == 0)
                drain();
        end
        drain();
    endtask

    // result checker
    task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %h actual %h", $realtime, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result word, expected none actual status %h",
                         $realtime, status);
            end
            else
            begin
                exp_r = pending_results.pop_front();
                words_checked++;
                check_field("status", exp_r.status, status);
                check_field("hit_slot", exp_r.hit_slot, hit_slot);
                check_field("assigned_port", exp_r.assigned_port, assigned_port);
                check_field("hdr_len", exp_r.hdr_len, hdr_len);
                check_field("out_dest_high", exp_r.out_dest_high, out_dest_high);
                check_field("out_dest_low", exp_r.out_dest_low, out_dest_low);
                check_field("out_dest_port", exp_r.out_dest_port, out_dest_port);
                check_field("out_is_ipv6", exp_r.out_is_ipv6, out_is_ipv6);
                check_field("peer_ip", exp_r.peer_ip, peer_ip);
                check_field("peer_port", exp_r.peer_port, peer_port);
                check_field("forward_len", exp_r.forward_len, forward_len);
                check_field("expired_count", exp_r.expired_count, expired_count);
            end
        end
    end

    // receiver stall
    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    // watchdog on cycles without any accepted word
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("udp_relay_session_table test failed");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        command = '0;
        now_ms = '0;
        cli_addr = '0;
        cli_port = '0;
        dest_high = '0;
        dest_low = '0;
        dst_port = '0;
        proxy_addr = '0;
        proxy_port = '0;
        slot = '0;
        datagram_len = '0;
        header_bytes = '0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        quiet_cycles = 0;
        idle_pct = 0;
        stall_pct = 0;
        idle_timeout = IDLE_RESET;
        port_cfg = '0;
        clock_ms = 32'hffff_0000;
        for (int i = 0; i < NUM_SLOTS; i++)
            sess_valid[i] = 1'b0;
        for (int i = 0; i < 8; i++)
            key_ip[i] = $urandom;
        for (int i = 0; i < 4; i++)
            key_port[i] = $urandom;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_full_table();
        test_random_phase(85, 0, 0, 32'd5000, 16'h1234);
        test_random_phase(85, 73, 0, 32'hffff_ffff, 16'hffff);
        test_random_phase(85, 0, 73, 32'd0, 16'h0000);
        test_random_phase(85, 19, 19, IDLE_RESET, 16'($urandom));
        test_random_phase(80, 0, 0, 32'd2500, 16'($urandom));

        $display("covered adds, duplicates, full table, lookups, inbound parsing and expiry");
        $display("%0d words sent, %0d results checked, %0d errors",
                 words_sent, words_checked, errors);
        if (errors == 0 && pending_results.size() == 0)
            $display("udp_relay_session_table test passed");
        else
            $display("udp_relay_session_table test failed");
        $finish;
    end

endmodule
